FILE: rtl/core/tbge_pkg.sv
// tbge_pkg: shared types, codes and helpers for the three-body euler step block
// used by tbge_alu and the top level; depends on nothing
`timescale 1ns / 1ps

package tbge_pkg;

    localparam int BODY_COUNT = 3;
    localparam int BODY_W     = 2;
    localparam logic [BODY_W-1:0] LAST_BODY = BODY_W'(BODY_COUNT - 1);

    // shared unit widths and step counts
    localparam int ALU_W      = 64;
    localparam int RES_W      = 80;
    localparam int MUL_STEPS  = 40;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 6;

    // clip level of intermediates is 2^39-1
    localparam int CAP_W = 39;
    localparam logic [CAP_W-1:0] INTER_CAP = '1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_ZERO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_ONE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_TWO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd4;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               clipped;
    } sat32_t;

    function automatic sat32_t clip32(input logic signed [63:0] v);
        sat32_t r;
        r.clipped = 1'b0;
        r.value   = v[31:0];
        if (v > 64'sh000000007FFFFFFF)
        begin
            r.clipped = 1'b1;
            r.value   = 32'sh7FFFFFFF;
        end
        else if (v < 64'shFFFFFFFF80000000)
        begin
            r.clipped = 1'b1;
            r.value   = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/three_body_gravity_euler_step.sv
// three_body_gravity_euler_step: top level, body state, sequencer and output register
// depends on tbge_pkg and tbge_alu
`timescale 1ns / 1ps
//
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+----------------------------
//  in       | in_valid, in_stall, command, body_index,  | one load or step item
//           | load_pos_x/y, load_vel_x/y                |
//  out      | out_valid, out_stall, result_body, new_*, | one body result, three per step
//           | acc_x/y, saturated, coincident, last      |
//  cfg      | cfg_we, cfg_index, cfg_data               | one register write
//
//  a step item is worked by the bit-serial shared unit: each of the six body pairs
//  needs four divides, six multiplies and a root, each body update four multiplies.
//  a coincident pair skips its arithmetic.
//  reset clears body state to zero and loads the default registers.
//  in_stall is high while a step item is in work; a held result stalls the sequencer
//  only when the next result is ready to be loaded.

module three_body_gravity_euler_step
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic [tbge_pkg::BODY_W-1:0]          body_index,
    input  logic signed [31:0]                   load_pos_x,
    input  logic signed [31:0]                   load_pos_y,
    input  logic signed [31:0]                   load_vel_x,
    input  logic signed [31:0]                   load_vel_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tbge_pkg::BODY_W-1:0]          result_body,
    output logic signed [31:0]                   new_pos_x,
    output logic signed [31:0]                   new_pos_y,
    output logic signed [31:0]                   new_vel_x,
    output logic signed [31:0]                   new_vel_y,
    output logic signed [31:0]                   acc_x,
    output logic signed [31:0]                   acc_y,
    output logic                                 saturated,
    output logic                                 coincident,
    output logic                                 last,
    input  logic                                 cfg_we,
    input  logic [tbge_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data
);

    localparam logic [FRACTION_BITS:0] UNIT = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam int CW = tbge_pkg::CAP_W;
    localparam int BW = tbge_pkg::BODY_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_I,
        S_RD_J,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_Q1,
        S_Q2,
        S_CDIV,
        S_TMUL,
        S_GMUL,
        S_NEXT,
        S_USTART,
        S_UMUL,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [BW-1:0]          bi_reg;
    logic [BW-1:0]          bj_reg;
    logic                   comp_reg;
    logic [1:0]             upd_reg;

    logic [31:0]            mass0_reg;
    logic [31:0]            mass1_reg;
    logic [31:0]            mass2_reg;
    logic [31:0]            grav_reg;
    logic [31:0]            dt_reg;

    logic signed [31:0]     pos_x_reg [tbge_pkg::BODY_COUNT];
    logic signed [31:0]     pos_y_reg [tbge_pkg::BODY_COUNT];
    logic signed [31:0]     vel_x_reg [tbge_pkg::BODY_COUNT];
    logic signed [31:0]     vel_y_reg [tbge_pkg::BODY_COUNT];
    logic signed [31:0]     ax_reg    [tbge_pkg::BODY_COUNT];
    logic signed [31:0]     ay_reg    [tbge_pkg::BODY_COUNT];
    logic [tbge_pkg::BODY_COUNT-1:0] sat_reg;
    logic [tbge_pkg::BODY_COUNT-1:0] coin_reg;

    logic [31:0]            lat_x_reg;
    logic [31:0]            lat_y_reg;
    logic [32:0]            dx_reg;
    logic [32:0]            dy_reg;
    logic [32:0]            mx_reg;
    logic [32:0]            my_reg;
    logic                   big_reg;
    logic [63:0]            sq_reg;
    logic [32:0]            r_reg;
    logic [CW-1:0]          q2_reg;
    logic signed [40:0]     sx_reg;
    logic signed [40:0]     sy_reg;

    logic                   out_valid_reg;
    logic [BW-1:0]          out_body_reg;
    logic signed [31:0]     out_px_reg;
    logic signed [31:0]     out_py_reg;
    logic signed [31:0]     out_vx_reg;
    logic signed [31:0]     out_vy_reg;
    logic signed [31:0]     out_ax_reg;
    logic signed [31:0]     out_ay_reg;
    logic                   out_sat_reg;
    logic                   out_coin_reg;
    logic                   out_last_reg;

    tbge_pkg::alu_req_t     alu_req;
    logic [63:0]            alu_a;
    logic [63:0]            alu_b;
    logic                   alu_done;
    logic [tbge_pkg::RES_W-1:0] alu_res;

    logic [BW-1:0]          rd_idx;
    logic [31:0]            px_rd;
    logic [31:0]            py_rd;
    logic [32:0]            dx_w;
    logic [32:0]            dy_w;
    logic [32:0]            mx_w;
    logic [32:0]            my_w;
    logic                   coin_w;
    logic                   big_w;
    logic [31:0]            hx_w;
    logic [31:0]            hy_r;
    logic [32:0]            r_w;
    logic [31:0]            mass_j;
    logic [63:0]            div_q;
    logic                   div_over;
    logic [CW-1:0]          div_cap;
    logic [FRACTION_BITS:0] cx_w;
    logic [tbge_pkg::RES_W-1:0] mul_sh;
    logic                   mul_over;
    logic [CW-1:0]          mul_cap;
    logic [40:0]            gext;
    logic [32:0]            dsel;
    logic signed [40:0]     ssel;
    logic signed [40:0]     snew;
    logic [BW-1:0]          j1;
    logic [BW-1:0]          j2;
    logic                   pair_end;
    tbge_pkg::sat32_t       clip_x;
    tbge_pkg::sat32_t       clip_y;
    logic signed [31:0]     usrc;
    logic signed [31:0]     ubase;
    logic [31:0]            umag;
    logic signed [63:0]     uscaled;
    tbge_pkg::sat32_t       uclip;
    logic                   out_free;

    tbge_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opa    (alu_a),
        .opb    (alu_b),
        .done   (alu_done),
        .result (alu_res)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_body = out_body_reg;
    assign new_pos_x   = out_px_reg;
    assign new_pos_y   = out_py_reg;
    assign new_vel_x   = out_vx_reg;
    assign new_vel_y   = out_vy_reg;
    assign acc_x       = out_ax_reg;
    assign acc_y       = out_ay_reg;
    assign saturated   = out_sat_reg;
    assign coincident  = out_coin_reg;
    assign last        = out_last_reg;
    assign out_free    = ~out_valid_reg | ~out_stall;

    // pair geometry
    assign rd_idx = (state_reg == S_RD_J) ? bj_reg : bi_reg;
    assign px_rd  = pos_x_reg[rd_idx];
    assign py_rd  = pos_y_reg[rd_idx];
    assign dx_w   = {lat_x_reg[31], lat_x_reg} - {px_rd[31], px_rd};
    assign dy_w   = {lat_y_reg[31], lat_y_reg} - {py_rd[31], py_rd};
    assign mx_w   = dx_w[32] ? (33'd0 - dx_w) : dx_w;
    assign my_w   = dy_w[32] ? (33'd0 - dy_w) : dy_w;
    assign coin_w = (mx_w == '0) && (my_w == '0);
    // halve both sides when a difference reaches 2^31 so the squares fit
    assign big_w  = mx_w[32] | mx_w[31] | my_w[32] | my_w[31];
    assign hx_w   = big_w ? mx_w[32:1] : mx_w[31:0];
    assign hy_r   = big_reg ? my_reg[32:1] : my_reg[31:0];
    assign r_w    = big_reg ? {alu_res[31:0], 1'b0} : {1'b0, alu_res[31:0]};

    always_comb
    begin
        case (bj_reg)
            2'd0:    mass_j = mass0_reg;
            2'd1:    mass_j = mass1_reg;
            default: mass_j = mass2_reg;
        endcase
    end

    assign div_q    = alu_res[63:0];
    assign div_over = |div_q[63:CW];
    assign div_cap  = div_over ? tbge_pkg::INTER_CAP : div_q[CW-1:0];
    assign cx_w     = (div_q > 64'(UNIT)) ? UNIT : div_q[FRACTION_BITS:0];
    assign mul_sh   = alu_res >> FRACTION_BITS;
    assign mul_over = |mul_sh[tbge_pkg::RES_W-1:CW];
    assign mul_cap  = mul_over ? tbge_pkg::INTER_CAP : mul_sh[CW-1:0];

    // accumulate -sign(d) * g
    assign gext = {2'b00, mul_cap};
    assign dsel = comp_reg ? dy_reg : dx_reg;
    assign ssel = comp_reg ? sy_reg : sx_reg;
    always_comb
    begin
        if (dsel[32])
            snew = ssel + $signed(gext);
        else if (dsel != '0)
            snew = ssel - $signed(gext);
        else
            snew = ssel;
    end

    assign j1       = bj_reg + 1'b1;
    assign j2       = (j1 == bi_reg) ? j1 + 1'b1 : j1;
    assign pair_end = (j2 > tbge_pkg::LAST_BODY);
    assign clip_x   = tbge_pkg::clip32({{23{sx_reg[40]}}, sx_reg});
    assign clip_y   = tbge_pkg::clip32({{23{sy_reg[40]}}, sy_reg});

    // body update: vel += acc*dt, then pos += vel*dt
    always_comb
    begin
        case (upd_reg)
            2'd0:
            begin
                usrc  = ax_reg[bi_reg];
                ubase = vel_x_reg[bi_reg];
            end
            2'd1:
            begin
                usrc  = ay_reg[bi_reg];
                ubase = vel_y_reg[bi_reg];
            end
            2'd2:
            begin
                usrc  = vel_x_reg[bi_reg];
                ubase = pos_x_reg[bi_reg];
            end
            default:
            begin
                usrc  = vel_y_reg[bi_reg];
                ubase = pos_y_reg[bi_reg];
            end
        endcase
    end

    assign umag    = usrc[31] ? (32'd0 - usrc) : usrc;
    assign uscaled = usrc[31] ? -$signed(mul_sh[63:0]) : $signed(mul_sh[63:0]);
    assign uclip   = tbge_pkg::clip32({{32{ubase[31]}}, ubase} + uscaled);

    always_comb
    begin
        alu_req.start = 1'b0;
        alu_req.op    = tbge_pkg::OP_MUL;
        alu_a         = '0;
        alu_b         = '0;
        case (state_reg)
            S_RD_J:
            begin
                alu_req.start = ~coin_w;
                alu_a         = 64'(hx_w);
                alu_b         = 64'(hx_w);
            end
            S_SQX:
            begin
                alu_req.start = alu_done;
                alu_a         = 64'(hy_r);
                alu_b         = 64'(hy_r);
            end
            S_SQY:
            begin
                alu_req.start = alu_done;
                alu_req.op    = tbge_pkg::OP_SQRT;
                alu_a         = sq_reg + alu_res[63:0];
            end
            S_ROOT:
            begin
                alu_req.start = alu_done;
                alu_req.op    = tbge_pkg::OP_DIV;
                alu_a         = (64'(mass_j) << FRACTION_BITS);
                alu_b         = 64'(r_w);
            end
            S_Q1:
            begin
                alu_req.start = alu_done;
                alu_req.op    = tbge_pkg::OP_DIV;
                alu_a         = (64'(div_cap) << FRACTION_BITS);
                alu_b         = 64'(r_reg);
            end
            S_Q2:
            begin
                alu_req.start = alu_done;
                alu_req.op    = tbge_pkg::OP_DIV;
                alu_a         = (64'(mx_reg) << FRACTION_BITS);
                alu_b         = 64'(r_reg);
            end
            S_CDIV:
            begin
                alu_req.start = alu_done;
                alu_a         = 64'(q2_reg);
                alu_b         = 64'(cx_w);
            end
            S_TMUL:
            begin
                alu_req.start = alu_done;
                alu_a         = 64'(grav_reg);
                alu_b         = 64'(mul_cap);
            end
            S_GMUL:
            begin
                alu_req.start = alu_done & ~comp_reg;
                alu_req.op    = tbge_pkg::OP_DIV;
                alu_a         = (64'(my_reg) << FRACTION_BITS);
                alu_b         = 64'(r_reg);
            end
            S_USTART:
            begin
                alu_req.start = 1'b1;
                alu_a         = 64'(umag);
                alu_b         = 64'(dt_reg);
            end
            default:
            begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bi_reg        <= '0;
            bj_reg        <= '0;
            comp_reg      <= 1'b0;
            upd_reg       <= '0;
            mass0_reg     <= 32'd65536;
            mass1_reg     <= 32'd65536;
            mass2_reg     <= 32'd65536;
            grav_reg      <= 32'd65536;
            dt_reg        <= 32'd655;
            for (int k = 0; k < tbge_pkg::BODY_COUNT; k++)
            begin
                pos_x_reg[k] <= '0;
                pos_y_reg[k] <= '0;
                vel_x_reg[k] <= '0;
                vel_y_reg[k] <= '0;
            end
            sat_reg       <= '0;
            coin_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tbge_pkg::CFG_MASS_ZERO: mass0_reg <= cfg_data;
                    tbge_pkg::CFG_MASS_ONE:  mass1_reg <= cfg_data;
                    tbge_pkg::CFG_MASS_TWO:  mass2_reg <= cfg_data;
                    tbge_pkg::CFG_GRAVITY:   grav_reg  <= cfg_data;
                    tbge_pkg::CFG_TIME_STEP: dt_reg    <= cfg_data;
                    default:                 dt_reg    <= dt_reg;
                endcase
            end

            // in emit the output register is either reloaded or still held
            if (out_valid_reg && !out_stall && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (command == tbge_pkg::CMD_STEP)
                        begin
                            bi_reg    <= '0;
                            bj_reg    <= 2'd1;
                            sx_reg    <= '0;
                            sy_reg    <= '0;
                            sat_reg   <= '0;
                            coin_reg  <= '0;
                            state_reg <= S_RD_I;
                        end
                        else if (body_index <= tbge_pkg::LAST_BODY)
                        begin
                            pos_x_reg[body_index] <= load_pos_x;
                            pos_y_reg[body_index] <= load_pos_y;
                            vel_x_reg[body_index] <= load_vel_x;
                            vel_y_reg[body_index] <= load_vel_y;
                        end
                    end
                end
                S_RD_I:
                begin
                    lat_x_reg <= px_rd;
                    lat_y_reg <= py_rd;
                    state_reg <= S_RD_J;
                end
                S_RD_J:
                begin
                    dx_reg  <= dx_w;
                    dy_reg  <= dy_w;
                    mx_reg  <= mx_w;
                    my_reg  <= my_w;
                    big_reg <= big_w;
                    if (coin_w)
                    begin
                        coin_reg[bi_reg] <= 1'b1;
                        state_reg        <= S_NEXT;
                    end
                    else
                        state_reg <= S_SQX;
                end
                S_SQX:
                begin
                    if (alu_done)
                    begin
                        sq_reg    <= alu_res[63:0];
                        state_reg <= S_SQY;
                    end
                end
                S_SQY:
                begin
                    if (alu_done)
                        state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (alu_done)
                    begin
                        r_reg     <= r_w;
                        state_reg <= S_Q1;
                    end
                end
                S_Q1:
                begin
                    if (alu_done)
                    begin
                        sat_reg[bi_reg] <= sat_reg[bi_reg] | div_over;
                        state_reg       <= S_Q2;
                    end
                end
                S_Q2:
                begin
                    if (alu_done)
                    begin
                        q2_reg          <= div_cap;
                        sat_reg[bi_reg] <= sat_reg[bi_reg] | div_over;
                        comp_reg        <= 1'b0;
                        state_reg       <= S_CDIV;
                    end
                end
                S_CDIV:
                begin
                    if (alu_done)
                        state_reg <= S_TMUL;
                end
                S_TMUL:
                begin
                    if (alu_done)
                    begin
                        sat_reg[bi_reg] <= sat_reg[bi_reg] | mul_over;
                        state_reg       <= S_GMUL;
                    end
                end
                S_GMUL:
                begin
                    if (alu_done)
                    begin
                        sat_reg[bi_reg] <= sat_reg[bi_reg] | mul_over;
                        if (comp_reg)
                        begin
                            sy_reg    <= snew;
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            sx_reg    <= snew;
                            comp_reg  <= 1'b1;
                            state_reg <= S_CDIV;
                        end
                    end
                end
                S_NEXT:
                begin
                    if (pair_end)
                    begin
                        ax_reg[bi_reg]  <= clip_x.value;
                        ay_reg[bi_reg]  <= clip_y.value;
                        sat_reg[bi_reg] <= sat_reg[bi_reg] | clip_x.clipped | clip_y.clipped;
                        sx_reg          <= '0;
                        sy_reg          <= '0;
                        if (bi_reg == tbge_pkg::LAST_BODY)
                        begin
                            bi_reg    <= '0;
                            upd_reg   <= '0;
                            state_reg <= S_USTART;
                        end
                        else
                        begin
                            bi_reg    <= bi_reg + 1'b1;
                            bj_reg    <= '0;
                            state_reg <= S_RD_I;
                        end
                    end
                    else
                    begin
                        bj_reg    <= j2;
                        state_reg <= S_RD_I;
                    end
                end
                S_USTART:
                begin
                    state_reg <= S_UMUL;
                end
                S_UMUL:
                begin
                    if (alu_done)
                    begin
                        case (upd_reg)
                            2'd0:    vel_x_reg[bi_reg] <= uclip.value;
                            2'd1:    vel_y_reg[bi_reg] <= uclip.value;
                            2'd2:    pos_x_reg[bi_reg] <= uclip.value;
                            default: pos_y_reg[bi_reg] <= uclip.value;
                        endcase
                        sat_reg[bi_reg] <= sat_reg[bi_reg] | uclip.clipped;
                        if (upd_reg == 2'd3)
                            state_reg <= S_EMIT;
                        else
                        begin
                            upd_reg   <= upd_reg + 1'b1;
                            state_reg <= S_USTART;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_body_reg  <= bi_reg;
                        out_px_reg    <= pos_x_reg[bi_reg];
                        out_py_reg    <= pos_y_reg[bi_reg];
                        out_vx_reg    <= vel_x_reg[bi_reg];
                        out_vy_reg    <= vel_y_reg[bi_reg];
                        out_ax_reg    <= ax_reg[bi_reg];
                        out_ay_reg    <= ay_reg[bi_reg];
                        out_sat_reg   <= sat_reg[bi_reg];
                        out_coin_reg  <= coin_reg[bi_reg];
                        out_last_reg  <= (bi_reg == tbge_pkg::LAST_BODY);
                        if (bi_reg == tbge_pkg::LAST_BODY)
                            state_reg <= S_IDLE;
                        else
                        begin
                            bi_reg    <= bi_reg + 1'b1;
                            upd_reg   <= '0;
                            state_reg <= S_USTART;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/tbge_alu.sv
// tbge_alu: bit-serial shared unit for multiply, restoring divide and integer root
// one step per cycle; depends on tbge_pkg
`timescale 1ns / 1ps

module tbge_alu
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tbge_pkg::alu_req_t           req,
    input  logic [tbge_pkg::ALU_W-1:0]   opa,
    input  logic [tbge_pkg::ALU_W-1:0]   opb,
    output logic                         done,
    output logic [tbge_pkg::RES_W-1:0]   result
);

    logic                          busy_reg;
    logic                          done_reg;
    tbge_pkg::alu_op_t             op_reg;
    logic [tbge_pkg::CNT_W-1:0]    cnt_reg;
    // r0: product / remainder / radicand, r1: multiplicand / quotient / root,
    // r2: multiplier / divisor / trial bit
    logic [tbge_pkg::RES_W-1:0]    r0_reg;
    logic [tbge_pkg::RES_W-1:0]    r1_reg;
    logic [tbge_pkg::ALU_W-1:0]    r2_reg;

    logic [tbge_pkg::RES_W-1:0]    mul_sum;
    logic [64:0]                   rem_sh;
    logic [65:0]                   div_diff;
    logic                          div_ge;
    logic [63:0]                   sq_trial;
    logic                          sq_ge;

    assign mul_sum  = r0_reg + r1_reg;
    assign rem_sh   = {r0_reg[63:0], r1_reg[63]};
    assign div_diff = {1'b0, rem_sh} - {2'b00, r2_reg};
    assign div_ge   = ~div_diff[65];
    assign sq_trial = r1_reg[63:0] + r2_reg;
    assign sq_ge    = (r0_reg[63:0] >= sq_trial);

    assign done   = done_reg;
    assign result = (op_reg == tbge_pkg::OP_MUL) ? r0_reg : {16'b0, r1_reg[63:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= tbge_pkg::OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                unique case (req.op)
                    tbge_pkg::OP_MUL:  cnt_reg <= tbge_pkg::CNT_W'(tbge_pkg::MUL_STEPS - 1);
                    tbge_pkg::OP_DIV:  cnt_reg <= tbge_pkg::CNT_W'(tbge_pkg::DIV_STEPS - 1);
                    tbge_pkg::OP_SQRT: cnt_reg <= tbge_pkg::CNT_W'(tbge_pkg::SQRT_STEPS - 1);
                    default:           cnt_reg <= '0;
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            unique case (req.op)
                tbge_pkg::OP_MUL:
                begin
                    r0_reg <= '0;
                    r1_reg <= {16'b0, opa};
                    r2_reg <= {24'b0, opb[39:0]};
                end
                tbge_pkg::OP_DIV:
                begin
                    r0_reg <= '0;
                    r1_reg <= {16'b0, opa};
                    r2_reg <= opb;
                end
                tbge_pkg::OP_SQRT:
                begin
                    r0_reg <= {16'b0, opa};
                    r1_reg <= '0;
                    r2_reg <= 64'h4000000000000000;
                end
                default:
                begin
                    r0_reg <= '0;
                    r1_reg <= '0;
                    r2_reg <= '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                tbge_pkg::OP_MUL:
                begin
                    if (r2_reg[0])
                        r0_reg <= mul_sum;
                    r1_reg <= {r1_reg[78:0], 1'b0};
                    r2_reg <= {1'b0, r2_reg[63:1]};
                end
                tbge_pkg::OP_DIV:
                begin
                    r0_reg <= div_ge ? {16'b0, div_diff[63:0]} : {16'b0, rem_sh[63:0]};
                    r1_reg <= {16'b0, r1_reg[62:0], div_ge};
                end
                tbge_pkg::OP_SQRT:
                begin
                    if (sq_ge)
                    begin
                        r0_reg <= {16'b0, r0_reg[63:0] - sq_trial};
                        r1_reg <= {16'b0, {1'b0, r1_reg[63:1]} + r2_reg};
                    end
                    else
                        r1_reg <= {16'b0, 1'b0, r1_reg[63:1]};
                    r2_reg <= {2'b00, r2_reg[63:2]};
                end
                default:
                begin
                    r0_reg <= r0_reg;
                end
            endcase
        end
    end

endmodule

FILE: bench/testbench.sv
// testbench: self-checking bench for three_body_gravity_euler_step
// drives load and step items with random gaps and stalls and checks every body result
// against a predictor kept here; depends on tbge_pkg and the rtl top level
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC = 16;
    localparam logic [63:0] UNIT = 64'd1 << FRAC;
    localparam logic [63:0] CAP = 64'h0000_007F_FFFF_FFFF;
    localparam int IDLE_LIMIT = 60000;
    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SMIN = 32'h8000_0000;
    localparam logic [31:0] UMAX = 32'hFFFF_FFFF;

    typedef struct {
        logic        cmd;
        logic [1:0]  idx;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        bit          typed;
    } body_cmd_t;

    typedef struct {
        logic [1:0]         body;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic               sat;
        logic               coin;
        logic               last;
    } body_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic command = tbge_pkg::CMD_LOAD;
    logic [tbge_pkg::BODY_W-1:0] body_index = '0;
    logic signed [31:0] load_pos_x = '0;
    logic signed [31:0] load_pos_y = '0;
    logic signed [31:0] load_vel_x = '0;
    logic signed [31:0] load_vel_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [tbge_pkg::BODY_W-1:0] result_body;
    logic signed [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y, acc_x, acc_y;
    logic saturated, coincident, last;
    logic cfg_we = 1'b0;
    logic [tbge_pkg::CFG_IDX_W-1:0] cfg_index = tbge_pkg::CFG_MASS_ZERO;
    logic [31:0] cfg_data = '0;

    // predictor state
    logic signed [31:0] body_px[3], body_py[3], body_vx[3], body_vy[3];
    logic [31:0] mass_reg[3];
    logic [31:0] gravity_reg, dt_reg;

    body_result_t expected_q[$];
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    three_body_gravity_euler_step u_top (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------- predictor arithmetic ----------------

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] cap39(input logic [63:0] v, inout bit f);
        if (v > CAP)
        begin
            f = 1'b1;
            return CAP;
        end
        return v;
    endfunction

    function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b,
                                          inout bit f);
        logic [127:0] p;
        if (a == 0 || b == 0)
            return 0;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:64] != 0)
        begin
            f = 1'b1;
            return CAP;
        end
        return cap39(p[63:0] >> FRAC, f);
    endfunction

    function automatic logic [63:0] div_q(input logic [63:0] a, input logic [63:0] r,
                                          inout bit f);
        return cap39((a << FRAC) / r, f);
    endfunction

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint scale_dt(input longint a, input logic [31:0] b);
        logic [63:0] p;
        p = (mag(a) * {32'd0, b}) >> FRAC;
        return a < 0 ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic signed [31:0] sat32(input longint v, inout bit f);
        if (v > longint'(2147483647))
        begin
            f = 1'b1;
            return SMAX;
        end
        if (v < -longint'(2147483647) - 1)
        begin
            f = 1'b1;
            return SMIN;
        end
        return v[31:0];
    endfunction

    // gravity from the old positions, then semi-implicit euler update of all bodies
    task automatic advance_bodies(input bit typed);
        longint ax[3], ay[3], sx, sy, dx, dy;
        bit sat_f[3], coin_f[3];
        bit s;
        logic [63:0] mx, my, r, q2, cx, cy, gx, gy;
        body_result_t res;
        for (int i = 0; i < 3; i++)
        begin
            sx = 0;
            sy = 0;
            s = 1'b0;
            coin_f[i] = 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                if (j == i)
                    continue;
                dx = longint'(body_px[i]) - longint'(body_px[j]);
                dy = longint'(body_py[i]) - longint'(body_py[j]);
                mx = mag(dx);
                my = mag(dy);
                if (mx == 0 && my == 0)
                begin
                    coin_f[i] = 1'b1;
                    continue;
                end
                if (mx >= 64'h8000_0000 || my >= 64'h8000_0000)
                    r = isqrt((mx >> 1) * (mx >> 1) + (my >> 1) * (my >> 1)) << 1;
                else
                    r = isqrt(mx * mx + my * my);
                q2 = div_q(div_q({32'd0, mass_reg[j]}, r, s), r, s);
                cx = (mx << FRAC) / r;
                cy = (my << FRAC) / r;
                if (cx > UNIT)
                    cx = UNIT;
                if (cy > UNIT)
                    cy = UNIT;
                gx = mul_q({32'd0, gravity_reg}, mul_q(q2, cx, s), s);
                gy = mul_q({32'd0, gravity_reg}, mul_q(q2, cy, s), s);
                sx += dx > 0 ? -longint'(gx) : (dx < 0 ? longint'(gx) : 0);
                sy += dy > 0 ? -longint'(gy) : (dy < 0 ? longint'(gy) : 0);
            end
            ax[i] = sat32(sx, s);
            ay[i] = sat32(sy, s);
            sat_f[i] = s;
        end
        for (int i = 0; i < 3; i++)
        begin
            s = sat_f[i];
            body_vx[i] = sat32(longint'(body_vx[i]) + scale_dt(ax[i], dt_reg), s);
            body_vy[i] = sat32(longint'(body_vy[i]) + scale_dt(ay[i], dt_reg), s);
            body_px[i] = sat32(longint'(body_px[i]) + scale_dt(body_vx[i], dt_reg), s);
            body_py[i] = sat32(longint'(body_py[i]) + scale_dt(body_vy[i], dt_reg), s);
            res.body = 2'(i);
            res.px = body_px[i];
            res.py = body_py[i];
            res.vx = body_vx[i];
            res.vy = body_vy[i];
            res.ax = ax[i][31:0];
            res.ay = ay[i][31:0];
            res.sat = s;
            res.coin = coin_f[i];
            res.last = (i == 2);
            if (typed)
            begin
                // all bodies at rest on the origin: every pair coincident, nothing moves
                res.px = 0; res.py = 0; res.vx = 0; res.vy = 0;
                res.ax = 0; res.ay = 0; res.sat = 1'b0; res.coin = 1'b1;
            end
            expected_q.push_back(res);
        end
    endtask

    // ---------------- driving ----------------

    task automatic send_item(input body_cmd_t it);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        command <= it.cmd;
        body_index <= it.idx;
        load_pos_x <= it.px;
        load_pos_y <= it.py;
        load_vel_x <= it.vx;
        load_vel_y <= it.vy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (it.cmd == tbge_pkg::CMD_STEP)
            advance_bodies(it.typed);
        else if (it.idx < 3)
        begin
            body_px[it.idx] = it.px;
            body_py[it.idx] = it.py;
            body_vx[it.idx] = it.vx;
            body_vy[it.idx] = it.vy;
        end
    endtask

    // waits for the block to drain, then writes all five registers
    task automatic set_registers(input logic [31:0] m0, input logic [31:0] m1,
                                 input logic [31:0] m2, input logic [31:0] g,
                                 input logic [31:0] dt);
        logic [31:0] vals[5];
        logic [tbge_pkg::CFG_IDX_W-1:0] idx_list[5];
        vals = '{m0, m1, m2, g, dt};
        idx_list = '{tbge_pkg::CFG_MASS_ZERO, tbge_pkg::CFG_MASS_ONE, tbge_pkg::CFG_MASS_TWO,
                     tbge_pkg::CFG_GRAVITY, tbge_pkg::CFG_TIME_STEP};
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        for (int k = 0; k < 5; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data <= vals[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        mass_reg = '{m0, m1, m2};
        gravity_reg = g;
        dt_reg = dt;
    endtask

    function automatic logic [31:0] pick_value(input int spread);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? SMAX : SMIN;
            default: return 32'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    function automatic logic [31:0] pick_register();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return UMAX;
            2: return $urandom;
            default: return $urandom_range(1, 1 << 20);
        endcase
    endfunction

    // ---------------- checking ----------------

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report(field, got, want);
    endtask

    always @(posedge clk)
    begin
        body_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report("unexpected body result", {30'd0, result_body}, 32'd0);
            else
            begin
                e = expected_q.pop_front();
                check_field("result_body", result_body, e.body);
                check_field("new_pos_x", new_pos_x, e.px);
                check_field("new_pos_y", new_pos_y, e.py);
                check_field("new_vel_x", new_vel_x, e.vx);
                check_field("new_vel_y", new_vel_y, e.vy);
                check_field("acc_x", acc_x, e.ax);
                check_field("acc_y", acc_y, e.ay);
                check_field("saturated", saturated, e.sat);
                check_field("coincident", coincident, e.coin);
                check_field("last", last, e.last);
            end
        end
    end

    // receiver stall pattern: a new mode is drawn each time the current one runs out
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 400);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 85);
            default: out_stall <= stall_left[2];
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    body_cmd_t directed_table[17] = '{
        '{tbge_pkg::CMD_STEP, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1},
        '{tbge_pkg::CMD_LOAD, 2'd3, UMAX, UMAX, UMAX, UMAX, 1'b0},
        '{tbge_pkg::CMD_LOAD, 2'd0, SMAX, SMIN, SMAX, SMIN, 1'b0},
        '{tbge_pkg::CMD_LOAD, 2'd1, SMIN, SMAX, SMIN, SMAX, 1'b0},
        '{tbge_pkg::CMD_LOAD, 2'd2, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0},
        '{tbge_pkg::CMD_STEP, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0},
        '{tbge_pkg::CMD_LOAD, 2'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b0},
        '{tbge_pkg::CMD_LOAD, 2'd1, 32'h0001_0000, 32'd0, 32'h0000_8000, 32'd0, 1'b0},
        '{tbge_pkg::CMD_LOAD, 2'd2, 32'hFFFF_0000, 32'h0002_0000, 32'd0, 32'hFFFF_8000,
          1'b0},
        '{tbge_pkg::CMD_STEP, 2'd3, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0},
        '{tbge_pkg::CMD_LOAD, 2'd2, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b0},
        '{tbge_pkg::CMD_STEP, 2'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0},
        // bodies one raw unit apart: huge accelerations clip
        '{tbge_pkg::CMD_LOAD, 2'd0, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0},
        '{tbge_pkg::CMD_LOAD, 2'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0},
        '{tbge_pkg::CMD_LOAD, 2'd2, 32'd0, 32'd1, 32'd0, 32'd0, 1'b0},
        '{tbge_pkg::CMD_STEP, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0},
        '{tbge_pkg::CMD_STEP, 2'd2, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0}
    };

    initial
    begin
        body_cmd_t it;
        int issued;
        int spread;
        int steps;
        for (int b = 0; b < 3; b++)
        begin
            body_px[b] = 0; body_py[b] = 0; body_vx[b] = 0; body_vy[b] = 0;
            mass_reg[b] = 32'd65536;
        end
        gravity_reg = 32'd65536;
        dt_reg = 32'd655;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[k])
            send_item(directed_table[k]);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_registers(32'd65536, 32'd131072, 32'd32768, 32'd65536, 32'd655);
                1: set_registers(UMAX, UMAX, UMAX, UMAX, UMAX);
                2: set_registers(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
                3: set_registers(32'd0, UMAX, $urandom, 32'd65536, 32'd655);
                default: set_registers(pick_register(), pick_register(), pick_register(),
                                       pick_register(), pick_register());
            endcase
            issued = 0;
            while (issued < 22)
            begin
                it.typed = 1'b0;
                if ($urandom_range(0, 9) < 7)
                begin
                    // well-formed: place all three bodies, then run a few steps
                    spread = $urandom_range(0, 1) ? (1 << 22) : (1 << 28);
                    for (int b = 0; b < 3; b++)
                    begin
                        it.cmd = tbge_pkg::CMD_LOAD;
                        it.idx = 2'(b);
                        it.px = pick_value(spread);
                        it.py = pick_value(spread);
                        it.vx = pick_value(1 << 18);
                        it.vy = pick_value(1 << 18);
                        send_item(it);
                    end
                    steps = $urandom_range(1, 3);
                    issued += 3 + steps;
                    for (int s = 0; s < steps; s++)
                    begin
                        it.cmd = tbge_pkg::CMD_STEP;
                        it.idx = 2'($urandom_range(0, 3));
                        it.px = $urandom; it.py = $urandom;
                        it.vx = $urandom; it.vy = $urandom;
                        send_item(it);
                    end
                end
                else
                begin
                    it.cmd = ($urandom_range(0, 3) == 0) ? tbge_pkg::CMD_STEP
                                                          : tbge_pkg::CMD_LOAD;
                    it.idx = 2'($urandom_range(0, 3));
                    it.px = $urandom; it.py = $urandom;
                    it.vx = $urandom; it.vy = $urandom;
                    send_item(it);
                    if (!(it.cmd == tbge_pkg::CMD_LOAD && it.idx == 2'd3))
                        issued++;
                end
            end
        end

        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
